// ===== sv/scv_pkg.sv =====
package scv_pkg;

    // Container framing
    localparam int HEADER_BYTES    = 48;
    localparam int FOOTER_BYTES    = 16;
    localparam int HASHED_BYTES    = 32;
    localparam int LENGTH_BITS_DEF = 32;
    localparam int HDR_IDX_W       = $clog2(HEADER_BYTES);
    localparam int FOOT_CNT_W      = $clog2(FOOTER_BYTES) + 1;

    // FNV-1a-64
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

    // "ANOS" and "ANOSDONE", first character in the lowest byte
    localparam logic [31:0] HEAD_MAGIC = 32'h534F4E41;
    localparam logic [63:0] TAIL_MAGIC = 64'h454E4F44534F4E41;

    // Configuration register indexes
    localparam logic CFG_CONTAINER_VERSION = 1'b0;
    localparam logic CFG_HASH_KIND_ID      = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_VALID    = 2'd0,
        VERDICT_REJECTED = 2'd1,
        VERDICT_DAMAGED  = 2'd2
    } verdict_t;

    // Running stream state handed to the verdict logic
    typedef struct packed {
        logic [63:0] hdr_hash;
        logic [63:0] pay_hash;
        logic [63:0] foot_word;
        logic        magic_bad;
        logic        plen_big;
    } scv_status_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] fmt_version;
        logic [31:0] min_rd_version;
        logic [63:0] sequence_number;
        logic [31:0] payload_length;
    } scv_result_t;

    // One FNV-1a step; the prime 0x100000001b3 as shifts and adds
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ===== sv/scv_track.sv =====
module scv_track
    import scv_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic [7:0]             data,
    input  logic                   last,
    output logic [LENGTH_BITS+1:0] total,
    output logic [LENGTH_BITS:0]   tot_end,
    output logic [7:0]             hdr [HEADER_BYTES],
    output scv_status_t            status
);

    localparam int CntW = LENGTH_BITS + 2;
    localparam int EndW = LENGTH_BITS + 1;
    localparam logic [CntW-1:0] HdrEnd  = CntW'(HEADER_BYTES);
    localparam logic [CntW-1:0] HashEnd = CntW'(HASHED_BYTES);
    localparam logic [CntW-1:0] HdrLast = CntW'(HEADER_BYTES - 1);
    localparam logic [FOOT_CNT_W-1:0] FootWordEnd = FOOT_CNT_W'(8);
    localparam logic [FOOT_CNT_W-1:0] FootEnd     = FOOT_CNT_W'(FOOTER_BYTES);

    logic [CntW-1:0]       count_reg,     count_next;
    logic [63:0]           hdr_hash_reg,  hdr_hash_next;
    logic [63:0]           pay_hash_reg,  pay_hash_next;
    logic [63:0]           foot_word_reg, foot_word_next;
    logic                  magic_bad_reg, magic_bad_next;
    logic [FOOT_CNT_W-1:0] foot_cnt_reg,  foot_cnt_next;
    logic [EndW-1:0]       pay_end_reg;
    logic [EndW-1:0]       tot_end_reg;
    logic                  plen_big_reg;
    logic [7:0]            hdr_reg [HEADER_BYTES];

    logic        sat, live, in_hdr, in_pay, in_foot, bad_hit;
    logic [63:0] plen64;

    assign sat     = &count_reg;
    assign live    = take && !sat;
    assign in_hdr  = count_reg < HdrEnd;
    assign in_pay  = !in_hdr && !plen_big_reg && (count_reg < {1'b0, pay_end_reg});
    assign in_foot = !in_hdr && !plen_big_reg && !in_pay;
    assign plen64  = {hdr_reg[23], hdr_reg[22], hdr_reg[21], hdr_reg[20],
                      hdr_reg[19], hdr_reg[18], hdr_reg[17], hdr_reg[16]};

    // footer magic byte that misses, on this very byte
    assign bad_hit = live && in_foot && !foot_cnt_reg[FOOT_CNT_W-1] && foot_cnt_reg[3]
                     && (data != TAIL_MAGIC[8*foot_cnt_reg[2:0] +: 8]);

    always_comb
    begin
        count_next     = count_reg;
        hdr_hash_next  = hdr_hash_reg;
        pay_hash_next  = pay_hash_reg;
        foot_word_next = foot_word_reg;
        magic_bad_next = magic_bad_reg | bad_hit;
        foot_cnt_next  = foot_cnt_reg;
        if (live)
        begin
            count_next = count_reg + CntW'(1);
            if (count_reg < HashEnd)
                hdr_hash_next = fnv_step(hdr_hash_reg, data);
            if (in_pay)
                pay_hash_next = fnv_step(pay_hash_reg, data);
            if (in_foot && foot_cnt_reg != FootEnd)
            begin
                if (foot_cnt_reg < FootWordEnd)
                    foot_word_next[8*foot_cnt_reg[2:0] +: 8] = data;
                foot_cnt_next = foot_cnt_reg + FOOT_CNT_W'(1);
            end
        end
        if (take && last)
        begin
            count_next     = '0;
            hdr_hash_next  = FNV_BASIS;
            pay_hash_next  = FNV_BASIS;
            foot_word_next = '0;
            magic_bad_next = 1'b0;
            foot_cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            hdr_hash_reg  <= FNV_BASIS;
            pay_hash_reg  <= FNV_BASIS;
            foot_word_reg <= '0;
            magic_bad_reg <= 1'b0;
            foot_cnt_reg  <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            hdr_hash_reg  <= hdr_hash_next;
            pay_hash_reg  <= pay_hash_next;
            foot_word_reg <= foot_word_next;
            magic_bad_reg <= magic_bad_next;
            foot_cnt_reg  <= foot_cnt_next;
        end
    end

    // header store and payload bounds, fixed once byte 47 goes by
    always_ff @(posedge clk)
    begin
        if (live && in_hdr)
            hdr_reg[count_reg[HDR_IDX_W-1:0]] <= data;
        if (live && count_reg == HdrLast)
        begin
            pay_end_reg  <= EndW'(HEADER_BYTES) + {1'b0, plen64[LENGTH_BITS-1:0]};
            tot_end_reg  <= EndW'(HEADER_BYTES + FOOTER_BYTES)
                            + {1'b0, plen64[LENGTH_BITS-1:0]};
            plen_big_reg <= (plen64 >> LENGTH_BITS) != 64'd0;
        end
    end

    // count including the byte now taken
    assign total   = sat ? count_reg : count_reg + CntW'(1);
    assign tot_end = tot_end_reg;
    assign hdr     = hdr_reg;

    assign status.hdr_hash  = hdr_hash_reg;
    assign status.pay_hash  = pay_hash_reg;
    assign status.foot_word = foot_word_reg;
    assign status.magic_bad = magic_bad_reg | bad_hit;
    assign status.plen_big  = plen_big_reg;

endmodule

// ===== sv/scv_judge.sv =====
module scv_judge
    import scv_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   judge_en,
    input  logic                   res_take,
    input  logic [15:0]            exp_version,
    input  logic [7:0]             exp_hash_id,
    input  logic [LENGTH_BITS+1:0] total,
    input  logic [LENGTH_BITS:0]   tot_end,
    input  logic [7:0]             hdr [HEADER_BYTES],
    input  scv_status_t            status,
    output logic                   res_valid,
    output scv_result_t            res
);

    localparam int CntW = LENGTH_BITS + 2;
    localparam logic [CntW-1:0] MinTotal = CntW'(HEADER_BYTES + FOOTER_BYTES);

    logic        res_valid_reg, res_valid_next;
    scv_result_t res_reg;
    verdict_t    verdict;
    logic [31:0] magic, fmt, minr, plen32;
    logic [15:0] ver;
    logic [63:0] hash_field, reserved, seq;

    assign magic      = {hdr[3], hdr[2], hdr[1], hdr[0]};
    assign ver        = {hdr[5], hdr[4]};
    assign fmt        = {hdr[11], hdr[10], hdr[9], hdr[8]};
    assign minr       = {hdr[15], hdr[14], hdr[13], hdr[12]};
    assign plen32     = {hdr[19], hdr[18], hdr[17], hdr[16]};
    assign seq        = {hdr[31], hdr[30], hdr[29], hdr[28],
                         hdr[27], hdr[26], hdr[25], hdr[24]};
    assign hash_field = {hdr[39], hdr[38], hdr[37], hdr[36],
                         hdr[35], hdr[34], hdr[33], hdr[32]};
    assign reserved   = {hdr[47], hdr[46], hdr[45], hdr[44],
                         hdr[43], hdr[42], hdr[41], hdr[40]};

    // length, header, body, versions; hashes final when the length matches
    always_comb
    begin
        priority if (total < MinTotal)
            verdict = VERDICT_REJECTED;
        else if (magic != HEAD_MAGIC || ver != exp_version || hdr[6] != exp_hash_id
                 || hdr[7] != 8'd0 || hash_field != status.hdr_hash || reserved != 64'd0)
            verdict = VERDICT_REJECTED;
        else if (status.plen_big || total != {1'b0, tot_end} || status.magic_bad
                 || status.foot_word != status.pay_hash)
            verdict = VERDICT_DAMAGED;
        else if (fmt == 32'd0 || minr == 32'd0 || minr > fmt)
            verdict = VERDICT_REJECTED;
        else
            verdict = VERDICT_VALID;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (judge_en)
            res_valid_next = 1'b1;
        else if (res_take)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (judge_en)
        begin
            res_reg.verdict <= verdict;
            if (verdict == VERDICT_VALID)
            begin
                res_reg.fmt_version     <= fmt;
                res_reg.min_rd_version  <= minr;
                res_reg.sequence_number <= seq;
                res_reg.payload_length  <= plen32;
            end
            else
            begin
                res_reg.fmt_version     <= '0;
                res_reg.min_rd_version  <= '0;
                res_reg.sequence_number <= '0;
                res_reg.payload_length  <= '0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/save_container_validator_core.sv =====
// Path: a last byte passes the input register, then the result register, which
// holds the verdict word until taken; the FNV step and checks are combinational.
// Throughput: one byte per cycle unless the stall below holds a last byte.
// A last byte waits in the input register while an untaken verdict word is held.
// Reset (rst_n, async, active low): stream state cleared, hashes at the FNV basis,
// container_version and hash_kind_id at 1, no word held on either side.
module save_container_validator_core
    import scv_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // byte stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] data_byte
    input  logic         s_tlast,    // last_byte
    // verdict out
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,    // [1:0] verdict, [33:2] fmt_version,
                                     // [65:34] min_rd_version,
                                     // [129:66] sequence_number,
                                     // [161:130] payload_length, rest zero
    // configuration writes
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    // configuration registers
    logic [15:0] cfg_version_reg;
    logic [7:0]  cfg_hash_id_reg;

    // input stage
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic        res_valid;
    logic        proc;
    logic        load;
    scv_result_t res;
    scv_status_t status;

    logic [LENGTH_BITS+1:0] total;
    logic [LENGTH_BITS:0]   tot_end;
    logic [7:0]             hdr [HEADER_BYTES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_version_reg <= 16'd1;
            cfg_hash_id_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CONTAINER_VERSION: cfg_version_reg <= cfg_data;
                CFG_HASH_KIND_ID:      cfg_hash_id_reg <= cfg_data[7:0];
                default:               ;
            endcase
        end
    end

    // The held byte moves on unless it is a last byte and the verdict register
    // still holds a word the sink has not taken. Non-last bytes never wait.
    assign proc     = in_valid_reg && !(in_last_reg && res_valid && !m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load)
            in_valid_next = 1'b1;
        else if (proc)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // byte count, header store, both hashes and the footer
    scv_track #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (proc),
        .data    (in_byte_reg),
        .last    (in_last_reg),
        .total   (total),
        .tot_end (tot_end),
        .hdr     (hdr),
        .status  (status)
    );

    // verdict checks and the result register
    scv_judge #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_judge (
        .clk         (clk),
        .rst_n       (rst_n),
        .judge_en    (proc && in_last_reg),
        .res_take    (m_tready),
        .exp_version (cfg_version_reg),
        .exp_hash_id (cfg_hash_id_reg),
        .total       (total),
        .tot_end     (tot_end),
        .hdr         (hdr),
        .status      (status),
        .res_valid   (res_valid),
        .res         (res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {6'd0, res.payload_length, res.sequence_number,
                       res.min_rd_version, res.fmt_version, res.verdict};

endmodule

// ===== bench/save_container_validator_core_tb.sv =====
module save_container_validator_core_tb
    import scv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // FNV-1a-64 multiplier; the package only carries the basis
    localparam logic [63:0] FNV_MULT   = 64'h00000100000001b3;
    localparam logic [33:0] COUNT_CAP  = '1;
    localparam logic [63:0] PLEN_LIMIT = 64'h00000000ffffffff;
    localparam int          STALL_LIMIT = 2000;
    localparam int          TARGET_BYTES = 1500;
    // Slack waited out after the block looks idle
    localparam int          DRAIN_CYCLES = 6;

    // Ways of shaping one container image
    typedef enum int {
        BUILD_CLEAN,
        BUILD_EXTREME_HIGH,
        BUILD_EXTREME_LOW,
        BUILD_NOISE,
        BUILD_TRUNC,
        BUILD_BAD_MAGIC,
        BUILD_BAD_VERSION,
        BUILD_BAD_HASH_ID,
        BUILD_FLAGS_SET,
        BUILD_BAD_HDR_HASH,
        BUILD_RESERVED_SET,
        BUILD_HUGE_LENGTH,
        BUILD_SHORT_BODY,
        BUILD_LONG_BODY,
        BUILD_BAD_TAIL,
        BUILD_BAD_PAY_HASH,
        BUILD_FMT_ZERO,
        BUILD_MINR_ZERO,
        BUILD_MINR_ABOVE
    } build_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } stream_byte_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] fmt_version;
        logic [31:0] min_rd_version;
        logic [63:0] sequence_number;
        logic [31:0] payload_length;
    } verdict_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic         cfg_index = CFG_CONTAINER_VERSION;
    logic [15:0]  cfg_data = 16'd0;

    save_container_validator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [7:0] data_byte
        .s_tlast  (s_tlast),     // last_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // [1:0] verdict, [33:2] fmt_version,
                                 // [65:34] min_rd_version,
                                 // [129:66] sequence_number,
                                 // [161:130] payload_length, rest zero
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    // Stimulus plumbing
    stream_byte_t  pending_bytes[$];
    verdict_word_t expected_verdicts[$];
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;
    logic          in_fire = 1'b0;

    // Generator side view of the registers, used to build matching headers
    logic [15:0]   gen_version = 16'd1;
    logic [7:0]    gen_hash_id = 8'd1;

    // Predictor copy of the block: registers and per-container stream state
    logic [15:0]   want_version = 16'd1;
    logic [7:0]    want_hash_id = 8'd1;
    logic [33:0]   seen_count = '0;
    logic [7:0]    hdr_copy[HEADER_BYTES];
    logic [63:0]   hdr_fnv = FNV_BASIS;
    logic [63:0]   body_fnv = FNV_BASIS;
    logic [63:0]   tail_word = '0;
    logic          tail_magic_bad = 1'b0;

    // Bookkeeping
    int errors = 0;
    int stall_cycles = 0;
    int containers_built = 0;
    int bytes_built = 0;
    int n_valid = 0;
    int n_rejected = 0;
    int n_damaged = 0;
    int settings_used = 1;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] hdr_le(input int at, input int n);
        logic [63:0] v;
        v = '0;
        for (int k = n - 1; k >= 0; k--)
            v = (v << 8) | 64'(hdr_copy[at + k]);
        return v;
    endfunction

    task automatic absorb_byte(input logic [7:0] b);
        logic [63:0] plen;
        logic [63:0] off;
        int          idx;
        // Saturated counter: byte is dropped, verdict will be a mismatch
        if (seen_count >= COUNT_CAP)
            return;
        if (seen_count < HEADER_BYTES)
        begin
            hdr_copy[seen_count[HDR_IDX_W-1:0]] = b;
            if (seen_count < HASHED_BYTES)
                hdr_fnv = (hdr_fnv ^ 64'(b)) * FNV_MULT;
        end
        else
        begin
            plen = hdr_le(16, 8);
            // Oversized length: body and footer are neither hashed nor checked
            if (plen <= PLEN_LIMIT)
            begin
                off = 64'(seen_count) - HEADER_BYTES;
                if (off < plen)
                begin
                    body_fnv = (body_fnv ^ 64'(b)) * FNV_MULT;
                end
                else
                begin
                    off = off - plen;
                    if (off < 8)
                    begin
                        tail_word = tail_word | (64'(b) << (8 * off));
                    end
                    else if (off < FOOTER_BYTES)
                    begin
                        idx = int'(off) - 8;
                        if (b != TAIL_MAGIC[8 * idx +: 8])
                            tail_magic_bad = 1'b1;
                    end
                end
            end
        end
        seen_count = seen_count + 1'b1;
    endtask

    function automatic verdict_t judge_container();
        logic [63:0] plen;
        logic [63:0] fmt;
        logic [63:0] minr;
        if (seen_count < HEADER_BYTES + FOOTER_BYTES)
            return VERDICT_REJECTED;
        if (hdr_le(0, 4) != 64'(HEAD_MAGIC))
            return VERDICT_REJECTED;
        if (hdr_le(4, 2) != 64'(want_version))
            return VERDICT_REJECTED;
        if (hdr_copy[6] != want_hash_id || hdr_copy[7] != 8'd0)
            return VERDICT_REJECTED;
        if (hdr_le(HASHED_BYTES, 8) != hdr_fnv)
            return VERDICT_REJECTED;
        if (hdr_le(40, 8) != 64'd0)
            return VERDICT_REJECTED;
        plen = hdr_le(16, 8);
        if (plen > PLEN_LIMIT)
            return VERDICT_DAMAGED;
        if (64'(seen_count) != HEADER_BYTES + FOOTER_BYTES + plen)
            return VERDICT_DAMAGED;
        if (tail_magic_bad)
            return VERDICT_DAMAGED;
        if (tail_word != body_fnv)
            return VERDICT_DAMAGED;
        // Version sanity is judged last, after the body checks
        fmt  = hdr_le(8, 4);
        minr = hdr_le(12, 4);
        if (fmt == 0 || minr == 0 || minr > fmt)
            return VERDICT_REJECTED;
        return VERDICT_VALID;
    endfunction

    function automatic verdict_word_t predict_verdict();
        verdict_word_t w;
        logic [63:0]   f;
        w = '0;
        w.verdict = judge_container();
        if (w.verdict == VERDICT_VALID)
        begin
            f = hdr_le(8, 4);
            w.fmt_version = f[31:0];
            f = hdr_le(12, 4);
            w.min_rd_version = f[31:0];
            w.sequence_number = hdr_le(24, 8);
            f = hdr_le(16, 8);
            w.payload_length = f[31:0];
        end
        return w;
    endfunction

    task automatic clear_stream();
        seen_count = '0;
        hdr_fnv = FNV_BASIS;
        body_fnv = FNV_BASIS;
        tail_word = '0;
        tail_magic_bad = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: one byte word per handshake, random gaps on the slave side
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_fire)
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_bytes[0].data;
                s_tlast  <= pending_bytes[0].is_last;
                void'(pending_bytes.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Master side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on accepted bytes, checks accepted verdict words
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        verdict_word_t want;
        if (rst_n)
        begin
            in_fire <= s_tvalid && s_tready;

            if (cfg_we)
            begin
                if (cfg_index == CFG_CONTAINER_VERSION)
                    want_version = cfg_data;
                else
                    want_hash_id = cfg_data[7:0];
            end

            if (s_tvalid && s_tready)
            begin
                absorb_byte(s_tdata);
                if (s_tlast)
                begin
                    want = predict_verdict();
                    expected_verdicts.push_back(want);
                    unique case (want.verdict)
                        VERDICT_VALID:    n_valid++;
                        VERDICT_REJECTED: n_rejected++;
                        default:          n_damaged++;
                    endcase
                    clear_stream();
                end
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: verdict word with nothing expected, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("verdict", 64'(want.verdict), 64'(m_tdata[1:0]));
                    check_field("fmt_version", 64'(want.fmt_version),
                                64'(m_tdata[33:2]));
                    check_field("min_rd_version", 64'(want.min_rd_version),
                                64'(m_tdata[65:34]));
                    check_field("sequence_number", want.sequence_number,
                                m_tdata[129:66]);
                    check_field("payload_length", 64'(want.payload_length),
                                64'(m_tdata[161:130]));
                    check_field("padding", 64'd0, 64'(m_tdata[167:162]));
                end
            end

            // Watchdog: cycles in which neither side moves a word
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Container image builder
    // ------------------------------------------------------------------

    task automatic queue_container(input build_kind_t kind);
        logic [7:0]  img[$];
        logic [7:0]  hdr[HEADER_BYTES];
        logic [63:0] hh;
        logic [63:0] ph;
        logic [63:0] plen_f;
        logic [63:0] seq;
        logic [31:0] fmt;
        logic [31:0] minr;
        logic [15:0] ver;
        logic [7:0]  hid;
        logic [7:0]  flags;
        logic [7:0]  b;
        int          n;
        int          cut;
        stream_byte_t item;

        // Mostly short bodies; now and then a long one
        n = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(12);
        ver   = gen_version;
        hid   = gen_hash_id;
        flags = 8'd0;
        fmt   = $urandom;
        if (fmt == 0)
            fmt = 32'd1;
        minr  = $urandom_range(fmt, 1);
        seq   = {$urandom, $urandom};
        plen_f = 64'(n);

        unique case (kind)
            BUILD_EXTREME_HIGH:
            begin
                fmt = '1;
                minr = '1;
                seq = '1;
            end
            BUILD_EXTREME_LOW:
            begin
                fmt = 32'd1;
                minr = 32'd1;
                seq = '0;
            end
            BUILD_BAD_VERSION: ver = ver ^ 16'($urandom_range(65535, 1));
            BUILD_BAD_HASH_ID: hid = hid ^ 8'($urandom_range(255, 1));
            BUILD_FLAGS_SET:   flags = 8'($urandom_range(255, 1));
            BUILD_HUGE_LENGTH: plen_f = {32'($urandom) | 32'd1, 32'($urandom)};
            BUILD_FMT_ZERO:    fmt = '0;
            BUILD_MINR_ZERO:   minr = '0;
            BUILD_MINR_ABOVE:
            begin
                fmt = $urandom_range(32'hfffffffe, 1);
                minr = $urandom_range(32'hffffffff, fmt + 1);
            end
            default: ;
        endcase

        for (int k = 0; k < 4; k++)
            hdr[k] = HEAD_MAGIC[8 * k +: 8];
        if (kind == BUILD_BAD_MAGIC)
            hdr[$urandom_range(3)] ^= 8'($urandom_range(255, 1));
        hdr[4] = ver[7:0];
        hdr[5] = ver[15:8];
        hdr[6] = hid;
        hdr[7] = flags;
        for (int k = 0; k < 4; k++)
        begin
            hdr[8 + k]  = fmt[8 * k +: 8];
            hdr[12 + k] = minr[8 * k +: 8];
        end
        for (int k = 0; k < 8; k++)
        begin
            hdr[16 + k] = plen_f[8 * k +: 8];
            hdr[24 + k] = seq[8 * k +: 8];
        end
        hh = FNV_BASIS;
        for (int k = 0; k < HASHED_BYTES; k++)
            hh = (hh ^ 64'(hdr[k])) * FNV_MULT;
        for (int k = 0; k < 8; k++)
        begin
            hdr[32 + k] = hh[8 * k +: 8];
            hdr[40 + k] = 8'd0;
        end
        if (kind == BUILD_BAD_HDR_HASH)
            hdr[32 + $urandom_range(7)] ^= 8'($urandom_range(255, 1));
        if (kind == BUILD_RESERVED_SET)
            hdr[40 + $urandom_range(7)] = 8'($urandom_range(255, 1));
        for (int k = 0; k < HEADER_BYTES; k++)
            img.push_back(hdr[k]);

        ph = FNV_BASIS;
        for (int k = 0; k < n; k++)
        begin
            if (kind == BUILD_EXTREME_HIGH)
                b = (k % 2) ? 8'hff : 8'h00;
            else
                b = 8'($urandom);
            ph = (ph ^ 64'(b)) * FNV_MULT;
            img.push_back(b);
        end
        if (kind == BUILD_BAD_PAY_HASH)
            ph = ph ^ (64'd1 << $urandom_range(63));
        for (int k = 0; k < 8; k++)
            img.push_back(ph[8 * k +: 8]);
        for (int k = 0; k < 8; k++)
            img.push_back(TAIL_MAGIC[8 * k +: 8]);

        unique case (kind)
            BUILD_BAD_TAIL:
                img[HEADER_BYTES + n + 8 + $urandom_range(7)] ^= 8'($urandom_range(255, 1));
            BUILD_SHORT_BODY:
                void'(img.pop_back());
            BUILD_LONG_BODY:
                img.push_back(8'($urandom));
            BUILD_TRUNC:
            begin
                // Either inside the header or just past it
                cut = $urandom_range(1) ? $urandom_range(63, 48) : $urandom_range(47, 1);
                while (img.size() > cut)
                    void'(img.pop_back());
            end
            BUILD_NOISE:
            begin
                img.delete();
                cut = $urandom_range(90, 1);
                for (int k = 0; k < cut; k++)
                    img.push_back(8'($urandom));
            end
            default: ;
        endcase

        for (int k = 0; k < img.size(); k++)
        begin
            item.data = img[k];
            item.is_last = (k == img.size() - 1);
            pending_bytes.push_back(item);
        end
        containers_built++;
        bytes_built += img.size();
    endtask

    // Wait until the block holds nothing: all bytes in, all verdicts out
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both registers, back to back; upper bits of the id write are don't-care
    task automatic set_config(input logic [15:0] ver, input logic [7:0] hid);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CONTAINER_VERSION;
        cfg_data  <= ver;
        @(negedge clk);
        cfg_index <= CFG_HASH_KIND_ID;
        cfg_data  <= {8'($urandom), hid};
        @(negedge clk);
        cfg_we    <= 1'b0;
        gen_version = ver;
        gen_hash_id = hid;
        settings_used++;
    endtask

    task automatic set_idling(input int phase);
        unique case (phase % 4)
            0:
            begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
            1:
            begin
                src_idle_pct = 68;
                sink_stall_pct = 0;
            end
            2:
            begin
                src_idle_pct = 0;
                sink_stall_pct = 68;
            end
            default:
            begin
                src_idle_pct = 26;
                sink_stall_pct = 26;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        int          roll;
        int          phase_bytes;
        int          phase_results;
        int          phase_budget;
        build_kind_t kind;
        stream_byte_t lone;

        for (int k = 0; k < HEADER_BYTES; k++)
            hdr_copy[k] = 8'd0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset register values, no idling
        set_idling(0);
        lone.data = 8'hff;
        lone.is_last = 1'b1;
        pending_bytes.push_back(lone);   // a lone last byte: too short
        lone.data = 8'h00;
        pending_bytes.push_back(lone);
        queue_container(BUILD_CLEAN);
        queue_container(BUILD_EXTREME_HIGH);
        queue_container(BUILD_EXTREME_LOW);
        for (int k = int'(BUILD_TRUNC); k <= int'(BUILD_MINR_ABOVE); k++)
            queue_container(build_kind_t'(k));
        queue_container(BUILD_NOISE);
        wait_idle();

        // Remaining byte budget shared by the random phases
        phase_budget = (TARGET_BYTES - bytes_built) / 6;

        // Random phases, each with its own register setting and idling mix
        for (int phase = 1; phase <= 6; phase++)
        begin
            wait_idle();
            unique case (phase)
                1: set_config(16'h0000, 8'h00);
                2: set_config(16'hffff, 8'hff);
                3: set_config(16'h0001, 8'h01);
                default: set_config(16'($urandom), 8'($urandom));
            endcase
            set_idling(phase);
            phase_bytes = 0;
            phase_results = 0;
            while (phase_results == 0 || phase_bytes < phase_budget)
            begin
                roll = $urandom_range(99);
                if (roll < 55)
                    kind = BUILD_CLEAN;
                else if (roll < 62)
                    kind = BUILD_NOISE;
                else if (roll < 66)
                    kind = $urandom_range(1) ? BUILD_EXTREME_HIGH : BUILD_EXTREME_LOW;
                else
                    kind = build_kind_t'($urandom_range(int'(BUILD_MINR_ABOVE),
                                                        int'(BUILD_TRUNC)));
                roll = bytes_built;
                queue_container(kind);
                phase_bytes += bytes_built - roll;
                phase_results++;
            end
        end

        wait_idle();

        $display("covered %0d containers, %0d bytes, %0d register settings",
                 containers_built, bytes_built, settings_used);
        $display("verdicts seen: %0d valid, %0d rejected, %0d damaged",
                 n_valid, n_rejected, n_damaged);
        if (errors == 0 && expected_verdicts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/scv_pkg.sv
sv/scv_track.sv
sv/scv_judge.sv
sv/save_container_validator_core.sv
bench/save_container_validator_core_tb.sv
